// ----- src/led_pkg.sv -----
// shared types, codes and constants of the edit distance engine
package led_pkg;

  // default longest word, in symbols
  localparam int MAX_LEN_DEFAULT = 32;

  // field widths
  localparam int MODE_W   = 2;
  localparam int SYMBOL_W = 8;
  localparam int DIST_W   = 6;

  // largest distance the result field holds
  localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

  // input modes
  localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END    = 2'd2;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } led_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic start;
    logic step;
    logic issue;
    logic finish;
  } led_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_more;
    logic sweep_done;
  } led_sts_t;

endpackage

// ----- src/led_if.sv -----
// valid/ready channel interfaces for input and result beats

interface led_in_if;
  import led_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SYMBOL_W-1:0] symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface led_out_if;
  import led_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);
endinterface

// ----- src/led_ram.sv -----
// generic single write port ram with registered read
module led_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/led_ctrl.sv -----
// controller state machine: beat intake, sweep sequencing, result register handshake
module led_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [1:0]                in_mode,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output led_pkg::led_cmd_t         cmd,
  input  led_pkg::led_sts_t         sts
);
  import led_pkg::*;

  led_state_t state, state_next;
  logic       out_vld, out_vld_next;
  logic       in_beat;

  assign in_beat   = in_valid && in_ready;
  assign out_valid = out_vld;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      out_vld <= out_vld_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    out_vld_next = out_vld && !out_ready;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_beat) begin
          unique case (in_mode)
            MODE_FIRST:  cmd.load_first  = 1'b1;
            MODE_SECOND: cmd.load_second = 1'b1;
            MODE_END: begin
              cmd.start  = 1'b1;
              state_next = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (!sts.sweep_done) begin
          cmd.step  = 1'b1;
          cmd.issue = sts.issue_more;
        end else if (!out_vld || out_ready) begin
          cmd.finish   = 1'b1;
          out_vld_next = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- src/led_datapath.sv -----
// datapath: word stores, lengths, systolic row of cost lanes, result registers
module led_datapath #(
  parameter int MAX_LEN = led_pkg::MAX_LEN_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  led_pkg::led_cmd_t                   cmd,
  output led_pkg::led_sts_t                   sts,
  input  logic [led_pkg::SYMBOL_W-1:0]        symbol,
  output logic [led_pkg::DIST_W-1:0]          distance,
  output logic                                overflow
);
  import led_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = $clog2(2 * MAX_LEN + 1);
  localparam int DW = LW;
  localparam int XW = (DW > DIST_W) ? DW : DIST_W;

  logic [LW-1:0]       first_len, second_len;
  logic                ovf_seen;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_inc;
  logic                iss_vld;
  logic [LW-1:0]       iss_row;
  logic [SYMBOL_W-1:0] ram_q;
  logic                first_full, second_full;

  // second word, one symbol per lane
  logic [SYMBOL_W-1:0] b_sym [MAX_LEN];

  // lane cost values and lane output pipeline
  logic [DW-1:0]       val    [MAX_LEN];
  logic [DW-1:0]       val_new[MAX_LEN];
  logic [SYMBOL_W-1:0] l_sym  [MAX_LEN];
  logic [DW-1:0]       l_left [MAX_LEN];
  logic [DW-1:0]       l_diag [MAX_LEN];
  logic                l_vld  [MAX_LEN];
  logic [SYMBOL_W-1:0] p_sym  [MAX_LEN];
  logic [DW-1:0]       p_left [MAX_LEN];
  logic [DW-1:0]       p_diag [MAX_LEN];
  logic                p_vld  [MAX_LEN];

  logic [LW-1:0]       last_col;
  logic [DW-1:0]       dist_full;
  logic [XW-1:0]       dist_ext;

  assign first_full  = (first_len  >= LW'(MAX_LEN));
  assign second_full = (second_len >= LW'(MAX_LEN));
  assign cnt_inc     = cnt + CW'(1);

  // status toward the controller
  assign sts.issue_more = (cnt < CW'(first_len));
  assign sts.sweep_done = (cnt == (CW'(first_len) + CW'(second_len)));

  // first word store, read one row symbol per sweep step while rows remain to issue
  led_ram #(
    .WIDTH (SYMBOL_W),
    .DEPTH (MAX_LEN)
  ) u_first_word (
    .clk   (clk),
    .we    (cmd.load_first && !first_full),
    .waddr (first_len[AW-1:0]),
    .wdata (symbol),
    .re    (cmd.issue),
    .raddr (cnt[AW-1:0]),
    .rdata (ram_q)
  );

  // lengths, overflow flag, sweep counter and row issue
  always_ff @(posedge clk) begin
    if (rst) begin
      first_len  <= '0;
      second_len <= '0;
      ovf_seen   <= 1'b0;
      cnt        <= '0;
      iss_vld    <= 1'b0;
    end else begin
      iss_vld <= cmd.issue;
      if (cmd.load_first) begin
        if (first_full) begin
          ovf_seen <= 1'b1;
        end else begin
          first_len <= first_len + LW'(1);
        end
      end
      if (cmd.load_second) begin
        if (second_full) begin
          ovf_seen <= 1'b1;
        end else begin
          second_len <= second_len + LW'(1);
        end
      end
      if (cmd.start) begin
        cnt <= '0;
      end else if (cmd.step) begin
        cnt <= cnt_inc;
      end
      if (cmd.finish) begin
        first_len  <= '0;
        second_len <= '0;
        ovf_seen   <= 1'b0;
      end
    end
  end

  // row index travels with the symbol read
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      iss_row <= cnt_inc[LW-1:0];
    end
  end

  // second word symbol write
  always_ff @(posedge clk) begin
    if (cmd.load_second && !second_full) begin
      b_sym[second_len[AW-1:0]] <= symbol;
    end
  end

  // lane row: lane k holds the cost of column k+1
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_lane
    logic [DW:0] up_c, left_c, diag_c, m1;
    logic        sub;

    // lane input: first lane from the row feed, others from the lane before
    if (k == 0) begin : g_feed
      assign l_sym[k]  = ram_q;
      assign l_left[k] = iss_row;
      assign l_diag[k] = iss_row - DW'(1);
      assign l_vld[k]  = iss_vld;
    end else begin : g_chain
      assign l_sym[k]  = p_sym[k-1];
      assign l_left[k] = p_left[k-1];
      assign l_diag[k] = p_diag[k-1];
      assign l_vld[k]  = p_vld[k-1];
    end

    // smallest of insertion, deletion and substitution cost
    always_comb begin
      sub    = (l_sym[k] != b_sym[k]);
      up_c   = {1'b0, val[k]} + (DW+1)'(1);
      left_c = {1'b0, l_left[k]} + (DW+1)'(1);
      diag_c = {1'b0, l_diag[k]} + (DW+1)'(sub);
      m1     = (up_c < left_c) ? up_c : left_c;
      m1     = (m1 < diag_c) ? m1 : diag_c;
      val_new[k] = m1[DW-1:0];
    end

    // lane valid pipeline
    always_ff @(posedge clk) begin
      if (rst || cmd.start) begin
        p_vld[k] <= 1'b0;
      end else begin
        p_vld[k] <= l_vld[k];
      end
    end

    // lane cost and forwarded values
    always_ff @(posedge clk) begin
      if (cmd.start) begin
        val[k] <= DW'(k + 1);
      end else if (l_vld[k]) begin
        val[k]    <= val_new[k];
        p_sym[k]  <= l_sym[k];
        p_left[k] <= val_new[k];
        p_diag[k] <= val[k];
      end
    end
  end

  // distance pick and saturation
  assign last_col  = second_len - LW'(1);
  assign dist_full = (second_len == '0) ? first_len : val[last_col[AW-1:0]];
  assign dist_ext  = XW'(dist_full);

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      distance <= (dist_ext > XW'(DIST_MAX)) ? DIST_MAX : dist_ext[DIST_W-1:0];
      overflow <= ovf_seen;
    end
  end

endmodule

// ----- src/levenshtein_distance_engine_unit.sv -----
// top level of the levenshtein edit distance engine
// A symbol beat (mode 0 for the first word, mode 1 for the second) is appended to
// its word; symbols past MAX_LEN are dropped and flag overflow.
// An end beat (mode 2) starts a sweep in which one cost row per cycle enters a
// systolic row of MAX_LEN lanes, one lane per column of the second word; the
// result lands in the output register once the sweep is done, later only while
// an earlier result still waits, and both words are then empty again. No beat is
// taken during the sweep.
// Symbol beats are taken while a result waits to be read.
// Mode 3 beats are taken and ignored. The distance saturates at 63.
module levenshtein_distance_engine_unit #(
  parameter int MAX_LEN = led_pkg::MAX_LEN_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  led_in_if.sink    in_ch,
  led_out_if.source out_ch
);
  import led_pkg::*;

  led_cmd_t cmd;
  led_sts_t sts;

  // control
  led_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  led_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .symbol   (in_ch.symbol),
    .distance (out_ch.distance),
    .overflow (out_ch.overflow)
  );

endmodule

// ----- test/led_result_checker.sv -----
// beat monitor, edit distance predictor and result comparison for the distance engine
`timescale 1ns / 100ps

module led_result_checker #(
  parameter int MAX_LEN = led_pkg::MAX_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  led_in_if           in_ch,
  led_out_if          out_ch,
  output int unsigned errors,
  output int unsigned outstanding
);
  import led_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } led_answer_t;

  // predicted word contents and lengths
  logic [SYMBOL_W-1:0] word_a [MAX_LEN];
  logic [SYMBOL_W-1:0] word_b [MAX_LEN];
  int unsigned         len_a;
  int unsigned         len_b;
  logic                truncated;

  // distances predicted but not yet seen on the result channel
  led_answer_t answers [$];
  int unsigned fail_count;

  initial begin
    errors      = 0;
    outstanding = 0;
    fail_count  = 0;
    len_a       = 0;
    len_b       = 0;
    truncated   = 1'b0;
  end

  // single cost row dynamic programme over the loaded words
  function automatic logic [DIST_W-1:0] edit_distance();
    int unsigned row [MAX_LEN+1];
    int unsigned diag, above, sub, best, total;
    int unsigned i, j;
    for (j = 0; j <= len_b; j++) row[j] = j;
    for (i = 1; i <= len_a; i++) begin
      diag   = row[0];
      row[0] = i;
      for (j = 1; j <= len_b; j++) begin
        above = row[j];
        sub   = (word_a[i-1] == word_b[j-1]) ? 0 : 1;
        best  = above + 1;
        if (row[j-1] + 1 < best) best = row[j-1] + 1;
        if (diag + sub < best) best = diag + sub;
        row[j] = best;
        diag   = above;
      end
    end
    total = row[len_b];
    if (total > DIST_MAX) return DIST_MAX;
    return DIST_W'(total);
  endfunction

  always @(posedge clk) begin
    led_answer_t got, want;
    if (rst) begin
      answers.delete();
      len_a     = 0;
      len_b     = 0;
      truncated = 1'b0;
    end else begin
      // result beat against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got.distance = out_ch.distance;
        got.overflow = out_ch.overflow;
        if (answers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result beat: distance %0d overflow %0b",
                     $realtime, got.distance, got.overflow);
        end else begin
          want = answers.pop_front();
          if (got.distance !== want.distance || got.overflow !== want.overflow) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result beat: expected distance %0d overflow %0b, got %0d %0b",
                       $realtime, want.distance, want.overflow,
                       got.distance, got.overflow);
          end
        end
      end

      // input beat updates the predicted words
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.mode)
          MODE_FIRST: begin
            if (len_a < MAX_LEN) begin
              word_a[len_a] = in_ch.symbol;
              len_a++;
            end else begin
              truncated = 1'b1;
            end
          end
          MODE_SECOND: begin
            if (len_b < MAX_LEN) begin
              word_b[len_b] = in_ch.symbol;
              len_b++;
            end else begin
              truncated = 1'b1;
            end
          end
          MODE_END: begin
            want.distance = edit_distance();
            want.overflow = truncated;
            answers.insert(answers.size(), want);
            len_a     = 0;
            len_b     = 0;
            truncated = 1'b0;
          end
          default: begin
            // unused mode leaves everything alone
          end
        endcase
      end
    end
    outstanding <= answers.size();
    errors      <= fail_count;
  end

endmodule

// ----- test/tb.sv -----
// stimulus, flow control and verdict for the edit distance engine
`timescale 1ns / 100ps

module tb;
  import led_pkg::*;

  localparam int MAX_LEN = MAX_LEN_DEFAULT;
  localparam int TARGET_BEATS = 500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  led_in_if  in_ch ();
  led_out_if out_ch ();

  int unsigned errors;
  int unsigned outstanding;
  int unsigned beats_sent;
  int unsigned quiet_cycles;
  bit          tx_idle;
  bit          rx_idle;

  levenshtein_distance_engine_unit #(
    .MAX_LEN (MAX_LEN)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  led_result_checker #(
    .MAX_LEN (MAX_LEN)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one input beat, with an optional gap of idle cycles ahead of it
  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [SYMBOL_W-1:0] sym);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.symbol <= sym;
    do @(posedge clk); while (!in_ch.ready);
    if (mode != MODE_UNUSED) beats_sent++;
  endtask

  // load two words in random interleaving, then close the pair
  // letters 0 means full byte range, otherwise a small alphabet for frequent matches
  task automatic send_pair(input int unsigned n_a, input int unsigned n_b,
                           input int unsigned letters, input bit disjoint, input bit noise);
    int unsigned left_a, left_b;
    bit          pick_a;
    logic [SYMBOL_W-1:0] sym;
    left_a = n_a;
    left_b = n_b;
    while (left_a + left_b > 0) begin
      pick_a = (left_b == 0) || (left_a != 0 && $urandom_range(0, 1) == 0);
      if (letters == 0) sym = SYMBOL_W'($urandom_range(0, 255));
      else sym = SYMBOL_W'(8'h61 + $urandom_range(0, letters - 1));
      if (!pick_a && disjoint) sym = sym | 8'h80;
      if (noise && $urandom_range(0, 9) == 0)
        send_beat(MODE_UNUSED, SYMBOL_W'($urandom_range(0, 255)));
      send_beat(pick_a ? MODE_FIRST : MODE_SECOND, sym);
      if (pick_a) left_a--;
      else left_b--;
    end
    send_beat(MODE_END, SYMBOL_W'($urandom_range(0, 255)));
  endtask

  // hold the sender idle until every predicted result is back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // receiver with random stalls per result beat
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = rx_idle ? $urandom_range(0, 19) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("levenshtein_distance_engine_unit: mismatch");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned n_a, n_b, letters;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_FIRST;
    in_ch.symbol = '0;
    beats_sent   = 0;
    quiet_cycles = 0;
    tx_idle      = 1'b0;
    rx_idle      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty pair, unused mode, byte extremes, one-sided and equal words
    send_beat(MODE_END, 8'hFF);
    send_beat(MODE_UNUSED, 8'h00);
    send_beat(MODE_END, 8'h00);
    send_beat(MODE_FIRST, 8'h00);
    send_beat(MODE_FIRST, 8'hFF);
    send_beat(MODE_SECOND, 8'hFF);
    send_beat(MODE_SECOND, 8'h00);
    send_beat(MODE_END, 8'h55);
    send_beat(MODE_FIRST, 8'hAA);
    send_beat(MODE_END, 8'hAA);
    send_beat(MODE_SECOND, 8'h61);
    send_beat(MODE_SECOND, 8'h62);
    send_beat(MODE_END, 8'h00);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_beat(MODE_FIRST, 8'h78);
    send_beat(MODE_SECOND, 8'h78);
    send_beat(MODE_FIRST, 8'h79);
    send_beat(MODE_SECOND, 8'h79);
    send_beat(MODE_UNUSED, 8'hFF);
    send_beat(MODE_FIRST, 8'h7A);
    send_beat(MODE_SECOND, 8'h7A);
    send_beat(MODE_END, 8'h01);
    drain();

    // full words, fully different, then truncation on each side, then full words over two letters
    send_pair(MAX_LEN, MAX_LEN, 1, 1'b1, 1'b0);
    send_pair(MAX_LEN + 2, 2, 2, 1'b0, 1'b0);
    send_pair(3, MAX_LEN + 1, 0, 1'b0, 1'b1);
    send_pair(MAX_LEN, MAX_LEN, 2, 1'b0, 1'b0);
    drain();

    // random pairs, mostly short, now and then long or past the word limit
    while (beats_sent < TARGET_BEATS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        n_a = $urandom_range(20, MAX_LEN + 3);
        n_b = $urandom_range(0, MAX_LEN + 3);
      end else begin
        n_a = $urandom_range(0, 8);
        n_b = $urandom_range(0, 8);
      end
      letters = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      send_pair(n_a, n_b, letters, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) drain();
    end

    // wait out the last sweep and any stray result
    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain();
    repeat (2 * MAX_LEN + 8) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("levenshtein_distance_engine_unit: match");
    end else begin
      $display("levenshtein_distance_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
